// ===== sv/rsi_pkg.sv =====
// Shared constants for the ray-sphere intersection block.
package rsi_pkg;

  localparam int RSI_COORD_WIDTH = 32;
  localparam int RSI_FRAC_BITS   = 16;

endpackage

// ===== sv/rsi_ifs.sv =====
// Stream interfaces for rays in and hit results out.
interface rsi_ray_if import rsi_pkg::*; #(
  parameter int COORD_WIDTH = RSI_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] sphere_radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    output ready
  );
endinterface

interface rsi_hit_if import rsi_pkg::*; #(
  parameter int COORD_WIDTH = RSI_COORD_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [COORD_WIDTH-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

// ===== sv/ray_sphere_intersection.sv =====
// Ray-sphere intersection pipeline: quadratic, exact discriminant, square root, two dividers.
// Takes one ray/sphere pair per cycle while ready is high and returns one hit result per pair, in order.
// Eight stages build a, h, c and the discriminant, 2*COORD_WIDTH+2 stages extract the square
// root one bit per stage, and COORD_WIDTH stages of restoring division run for both roots
// side by side.
// A stall at the result port is taken by a skid register, so the pipe keeps moving while
// one result waits; ready drops only when that skid register is full.
module ray_sphere_intersection import rsi_pkg::*; #(
  parameter int COORD_WIDTH = RSI_COORD_WIDTH,
  parameter int FRAC_BITS   = RSI_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  rsi_ray_if.sink   ray,
  rsi_hit_if.source result
);

  localparam int CW   = COORD_WIDTH;
  localparam int LW   = CW + 1;          // origin minus center
  localparam int AW   = 2 * CW;          // a, unsigned
  localparam int HW   = 2 * CW + 2;      // h, signed
  localparam int CCW  = 2 * CW + 3;      // c, signed
  localparam int HMW  = 2 * CW + 1;      // |h|
  localparam int CMW  = 2 * CW + 2;      // |c|
  localparam int K    = CW + 1;          // split point of the wide products
  localparam int HHW  = HMW - K;
  localparam int AHW  = AW - K;
  localparam int CHW  = CMW - K;
  localparam int PW   = 4 * CW + 2;      // h*h and |a*c|
  localparam int DSW  = 4 * CW + 4;      // discriminant, signed
  localparam int RB   = DSW / 2;         // root bits
  localparam int EW   = RB + 4;
  localparam int QSW  = 2 * CW + 4;      // q, signed
  localparam int QMW  = 2 * CW + 3;      // |q|
  localparam int DVW  = QMW;             // divisor width
  localparam int NW   = QMW + FRAC_BITS; // numerator width
  localparam int QB   = CW;              // quotient bits
  localparam int CMPW = (NW > DVW + QB) ? NW : DVW + QB;

  typedef struct packed {
    logic signed [HW-1:0] h;
    logic [AW-1:0]        a;
    logic [CMW-1:0]       cm;
    logic                 cneg;
    logic                 azero;
  } ctx_t;

  typedef struct packed {
    logic [DSW-1:0] rad;
    logic [RB-1:0]  root;
    logic [RB+1:0]  rem;
    ctx_t           cx;
    logic           miss;
    logic           dz;
  } sq_t;

  typedef struct packed {
    logic [QB-1:0]  nlow;
    logic [DVW-1:0] d;
    logic [DVW-1:0] r;
    logic [QB-1:0]  quot;
    logic           big;
    logic           sign;
  } dvr_t;

  typedef struct packed {
    dvr_t t0;
    dvr_t t1;
    logic miss;
    logic dz;
  } dv_t;

  logic adv;

  // output and skid registers
  logic           out_v;
  logic           out_hit;
  logic [CW-1:0]  out_dist;
  logic           sk_v;
  logic           sk_hit;
  logic [CW-1:0]  sk_dist;

  assign adv       = !sk_v;
  assign ray.ready = adv;

  // stage 1: L = O - C
  logic                 v1;
  logic signed [LW-1:0] l1 [3];
  logic signed [CW-1:0] d1 [3];
  logic [CW-2:0]        r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1[0] <= LW'(ray.origin_x) - LW'(ray.center_x);
      l1[1] <= LW'(ray.origin_y) - LW'(ray.center_y);
      l1[2] <= LW'(ray.origin_z) - LW'(ray.center_z);
      d1[0] <= ray.dir_x;
      d1[1] <= ray.dir_y;
      d1[2] <= ray.dir_z;
      r1    <= ray.sphere_radius;
    end
  end

  // stage 2: component products
  logic                     v2;
  logic signed [2*CW-1:0]   dd2 [3];
  logic signed [2*CW:0]     dl2 [3];
  logic signed [2*CW+1:0]   ll2 [3];
  logic [2*CW-3:0]          rr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd2[i] <= (2*CW)'(d1[i]) * (2*CW)'(d1[i]);
        dl2[i] <= (2*CW+1)'(d1[i]) * (2*CW+1)'(l1[i]);
        ll2[i] <= (2*CW+2)'(l1[i]) * (2*CW+2)'(l1[i]);
      end
      rr2 <= (2*CW-2)'(r1) * (2*CW-2)'(r1);
    end
  end

  // stage 3: a, h, c
  logic                  v3;
  logic [AW-1:0]         a3;
  logic signed [HW-1:0]  h3;
  logic signed [CCW-1:0] c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= AW'($unsigned(dd2[0])) + AW'($unsigned(dd2[1])) + AW'($unsigned(dd2[2]));
      h3 <= HW'(dl2[0]) + HW'(dl2[1]) + HW'(dl2[2]);
      c3 <= CCW'(ll2[0]) + CCW'(ll2[1]) + CCW'(ll2[2]) - CCW'($signed({1'b0, rr2}));
    end
  end

  // stage 4: magnitudes
  logic           v4;
  ctx_t           cx4;
  logic [HMW-1:0] hm4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hm4       <= HMW'(h3[HW-1] ? -h3 : h3);
      cx4.h     <= h3;
      cx4.a     <= a3;
      cx4.cm    <= CMW'(c3[CCW-1] ? -c3 : c3);
      cx4.cneg  <= c3[CCW-1];
      cx4.azero <= (a3 == '0);
    end
  end

  // stage 5: partial products of h*h and a*|c|
  logic               v5;
  ctx_t               cx5;
  logic [2*K-1:0]     p_hll5;
  logic [K+HHW-1:0]   p_hlh5;
  logic [2*HHW-1:0]   p_hhh5;
  logic [2*K-1:0]     p_all5;
  logic [K+CHW-1:0]   p_alh5;
  logic [AHW+K-1:0]   p_ahl5;
  logic [AHW+CHW-1:0] p_ahh5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx5    <= cx4;
      p_hll5 <= (2*K)'(hm4[K-1:0]) * (2*K)'(hm4[K-1:0]);
      p_hlh5 <= (K+HHW)'(hm4[K-1:0]) * (K+HHW)'(hm4[HMW-1:K]);
      p_hhh5 <= (2*HHW)'(hm4[HMW-1:K]) * (2*HHW)'(hm4[HMW-1:K]);
      p_all5 <= (2*K)'(cx4.a[K-1:0]) * (2*K)'(cx4.cm[K-1:0]);
      p_alh5 <= (K+CHW)'(cx4.a[K-1:0]) * (K+CHW)'(cx4.cm[CMW-1:K]);
      p_ahl5 <= (AHW+K)'(cx4.a[AW-1:K]) * (AHW+K)'(cx4.cm[K-1:0]);
      p_ahh5 <= (AHW+CHW)'(cx4.a[AW-1:K]) * (AHW+CHW)'(cx4.cm[CMW-1:K]);
    end
  end

  // stage 6: h*h complete, cross terms of a*|c|
  logic                 v6;
  ctx_t                 cx6;
  logic [PW-1:0]        hsq6;
  logic [K+CHW:0]       cross6;
  logic [2*K-1:0]       p_all6;
  logic [AHW+CHW-1:0]   p_ahh6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx6    <= cx5;
      hsq6   <= (PW'(p_hhh5) << (2*K)) + (PW'(p_hlh5) << (K+1)) + PW'(p_hll5);
      cross6 <= (K+CHW+1)'(p_alh5) + (K+CHW+1)'(p_ahl5);
      p_all6 <= p_all5;
      p_ahh6 <= p_ahh5;
    end
  end

  // stage 7: |a*c| complete
  logic          v7;
  ctx_t          cx7;
  logic [PW-1:0] hsq7;
  logic [PW-1:0] acm7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx7  <= cx6;
      hsq7 <= hsq6;
      acm7 <= (PW'(p_ahh6) << (2*K)) + (PW'(cross6) << K) + PW'(p_all6);
    end
  end

  // stage 8: discriminant h*h - a*c
  logic                  v8;
  ctx_t                  cx8;
  logic signed [DSW-1:0] disc8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx8   <= cx7;
      disc8 <= cx7.cneg ? DSW'(hsq7) + DSW'(acm7) : DSW'(hsq7) - DSW'(acm7);
    end
  end

  // square root, one root bit per stage
  logic sqv [RB+1];
  sq_t  sq  [RB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (adv) begin
      sqv[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].rad  <= disc8[DSW-1] ? '0 : DSW'($unsigned(disc8));
      sq[0].root <= '0;
      sq[0].rem  <= '0;
      sq[0].cx   <= cx8;
      sq[0].miss <= cx8.azero || disc8[DSW-1];
      sq[0].dz   <= (disc8 == '0);
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [EW-1:0] remx;
    logic [EW-1:0] trial;
    logic          ge;
    sq_t           nxt;

    always_comb begin
      remx  = {sq[j].rem, sq[j].rad[DSW-1:DSW-2]};
      trial = EW'({sq[j].root, 2'b01});
      ge    = (remx >= trial);
      nxt   = sq[j];
      nxt.rad  = sq[j].rad << 2;
      nxt.root = {sq[j].root[RB-2:0], ge};
      nxt.rem  = ge ? (RB+2)'(remx - trial) : (RB+2)'(remx);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[j+1] <= 1'b0;
      end else if (adv) begin
        sqv[j+1] <= sqv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1] <= nxt;
      end
    end
  end

  // q from the stable root pair
  logic                  vq;
  logic signed [QSW-1:0] qq;
  ctx_t                  cxq;
  logic                  missq;
  logic                  dzq;
  logic                  hpos;

  assign hpos = !sq[RB].cx.h[HW-1] && (sq[RB].cx.h != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (adv) begin
      vq <= sqv[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qq    <= hpos ? -(QSW'(sq[RB].cx.h) + QSW'($signed({1'b0, sq[RB].root})))
                    : QSW'($signed({1'b0, sq[RB].root})) - QSW'(sq[RB].cx.h);
      cxq   <= sq[RB].cx;
      missq <= sq[RB].miss;
      dzq   <= sq[RB].dz;
    end
  end

  // |q|
  logic           vqa;
  logic [QMW-1:0] qma;
  logic           qnega;
  ctx_t           cxqa;
  logic           missqa;
  logic           dzqa;

  always_ff @(posedge clk) begin
    if (rst) begin
      vqa <= 1'b0;
    end else if (adv) begin
      vqa <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qma    <= QMW'(qq[QSW-1] ? -qq : qq);
      qnega  <= qq[QSW-1];
      cxqa   <= cxq;
      missqa <= missq;
      dzqa   <= dzq;
    end
  end

  // divider operands: q/a and c/q, both scaled by the fraction bits
  logic           vds;
  logic [NW-1:0]  n0ds;
  logic [NW-1:0]  n1ds;
  logic [DVW-1:0] d0ds;
  logic [DVW-1:0] d1ds;
  logic           s0ds;
  logic           s1ds;
  logic           missds;
  logic           dzds;

  always_ff @(posedge clk) begin
    if (rst) begin
      vds <= 1'b0;
    end else if (adv) begin
      vds <= vqa;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n0ds   <= {qma, {FRAC_BITS{1'b0}}};
      d0ds   <= DVW'(cxqa.a);
      s0ds   <= qnega;
      n1ds   <= NW'({cxqa.cm, {FRAC_BITS{1'b0}}});
      d1ds   <= qma;
      s1ds   <= cxqa.cneg ^ qnega;
      missds <= missqa;
      dzds   <= dzqa;
    end
  end

  // restoring division, one quotient bit per stage
  logic dvv [QB+1];
  dv_t  dv  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= vds;
    end
  end

  // a quotient that does not fit the distance width only needs the overflow flag
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].t0.big  <= CMPW'(n0ds) >= CMPW'({d0ds, {QB{1'b0}}});
      dv[0].t0.r    <= DVW'(n0ds >> QB);
      dv[0].t0.nlow <= n0ds[QB-1:0];
      dv[0].t0.d    <= d0ds;
      dv[0].t0.quot <= '0;
      dv[0].t0.sign <= s0ds;
      dv[0].t1.big  <= CMPW'(n1ds) >= CMPW'({d1ds, {QB{1'b0}}});
      dv[0].t1.r    <= DVW'(n1ds >> QB);
      dv[0].t1.nlow <= n1ds[QB-1:0];
      dv[0].t1.d    <= d1ds;
      dv[0].t1.quot <= '0;
      dv[0].t1.sign <= s1ds;
      dv[0].miss    <= missds;
      dv[0].dz      <= dzds;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DVW:0] rs0;
    logic [DVW:0] rs1;
    logic         ge0;
    logic         ge1;
    dv_t          nxt;

    always_comb begin
      rs0 = {dv[j].t0.r, dv[j].t0.nlow[QB-1]};
      rs1 = {dv[j].t1.r, dv[j].t1.nlow[QB-1]};
      ge0 = (rs0 >= {1'b0, dv[j].t0.d});
      ge1 = (rs1 >= {1'b0, dv[j].t1.d});
      nxt = dv[j];
      nxt.t0.r    = ge0 ? DVW'(rs0 - {1'b0, dv[j].t0.d}) : DVW'(rs0);
      nxt.t0.nlow = dv[j].t0.nlow << 1;
      nxt.t0.quot = {dv[j].t0.quot[QB-2:0], ge0};
      nxt.t1.r    = ge1 ? DVW'(rs1 - {1'b0, dv[j].t1.d}) : DVW'(rs1);
      nxt.t1.nlow = dv[j].t1.nlow << 1;
      nxt.t1.quot = {dv[j].t1.quot[QB-2:0], ge1};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else if (adv) begin
        dvv[j+1] <= dvv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1] <= nxt;
      end
    end
  end

  // root ordering and selection
  logic          pv;
  logic          neg0;
  logic          neg1;
  logic          big0;
  logic          big1;
  logic [QB-1:0] quo0;
  logic [QB-1:0] quo1;
  logic          pick0;
  logic          fin_hit;
  logic [CW-1:0] fin_dist;

  assign pv = dvv[QB];

  always_comb begin
    neg0 = dv[QB].t0.sign && (dv[QB].t0.big || (dv[QB].t0.quot != '0));
    big0 = dv[QB].t0.big;
    quo0 = dv[QB].t0.quot;
    // a zero discriminant gives a double root
    if (dv[QB].dz) begin
      neg1 = neg0;
      big1 = big0;
      quo1 = quo0;
    end else begin
      neg1 = dv[QB].t1.sign && (dv[QB].t1.big || (dv[QB].t1.quot != '0));
      big1 = dv[QB].t1.big;
      quo1 = dv[QB].t1.quot;
    end
    if (neg0) begin
      pick0 = 1'b0;
    end else if (neg1) begin
      pick0 = 1'b1;
    end else begin
      pick0 = big1 || (!big0 && (quo0 <= quo1));
    end
    fin_hit = !dv[QB].miss && !(neg0 && neg1);
    if (!fin_hit) begin
      fin_dist = '1;
    end else if (pick0) begin
      fin_dist = big0 ? '1 : quo0;
    end else begin
      fin_dist = big1 ? '1 : quo1;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else begin
      if (!out_v || result.ready) begin
        if (sk_v) begin
          out_v    <= 1'b1;
          out_hit  <= sk_hit;
          out_dist <= sk_dist;
          sk_v     <= 1'b0;
        end else begin
          out_v    <= pv;
          out_hit  <= fin_hit;
          out_dist <= fin_dist;
        end
      end else if (pv && adv) begin
        sk_v    <= 1'b1;
        sk_hit  <= fin_hit;
        sk_dist <= fin_dist;
      end
    end
  end

  assign result.valid    = out_v;
  assign result.hit      = out_hit;
  assign result.distance = out_dist;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid register full with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_v) |-> $past(out_v && !result.ready))
    else $error("skid register filled without an output stall");

  a_miss_all_ones: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.hit) |-> (result.distance == '1))
    else $error("miss without all-ones distance");

endmodule

// ===== tb/rsi_hit_checker.sv =====
// Checker: predicts each ray/sphere result and compares it with the returned stream.
`timescale 1ns / 100ps
module rsi_hit_checker import rsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  rsi_ray_if   ray,
  rsi_hit_if   result,
  output int   fail_count,
  output int   pending
);

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic                          hit;
    logic [RSI_COORD_WIDTH-1:0]    distance;
  } hit_res_t;

  hit_res_t expected_hits[$];

  initial fail_count = 0;
  assign pending = expected_hits.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic big_t floor_sqrt(input big_t v);
    big_t root, cand;
    root = '0;
    for (int k = 110; k >= 0; k--) begin
      cand = root | (big_t'(1) <<< k);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Exact quadratic in wide integers; the stable root pair avoids cancellation.
  function automatic hit_res_t nearest_hit(
    input logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
    input logic [30:0] rad
  );
    big_t a, h, c, disc, s, q, t0, t1, tmp, lx, ly, lz, bx, by, bz, br;
    hit_res_t res;
    res.hit = 1'b0;
    res.distance = '1;
    bx = dx; by = dy; bz = dz;
    lx = big_t'(ox) - big_t'(cx);
    ly = big_t'(oy) - big_t'(cy);
    lz = big_t'(oz) - big_t'(cz);
    br = big_t'({1'b0, rad});
    a = bx * bx + by * by + bz * bz;
    h = bx * lx + by * ly + bz * lz;
    c = lx * lx + ly * ly + lz * lz - br * br;
    if (a != 0) begin
      disc = h * h - a * c;
      if (disc >= 0) begin
        if (disc == 0) begin
          t0 = ((-h) <<< RSI_FRAC_BITS) / a;
          t1 = t0;
        end else begin
          s = floor_sqrt(disc);
          q = (h > 0) ? -(h + s) : (s - h);
          t0 = (q <<< RSI_FRAC_BITS) / a;
          t1 = (c <<< RSI_FRAC_BITS) / q;
        end
        if (t0 > t1) begin
          tmp = t0; t0 = t1; t1 = tmp;
        end
        if (t0 < 0) t0 = t1;
        if (t0 >= 0) begin
          res.hit = 1'b1;
          res.distance = (t0 > big_t'(32'hFFFF_FFFF)) ? '1 : t0[31:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hit_res_t want;
    if (!rst) begin
      if (ray.valid && ray.ready)
        expected_hits.push_back(nearest_hit(ray.origin_x, ray.origin_y, ray.origin_z,
          ray.dir_x, ray.dir_y, ray.dir_z, ray.center_x, ray.center_y, ray.center_z,
          ray.sphere_radius));
      if (result.valid && result.ready) begin
        if (expected_hits.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = expected_hits.pop_front();
          if (result.hit !== want.hit)
            report($sformatf("hit %b, expected %b", result.hit, want.hit));
          if (result.distance !== want.distance)
            report($sformatf("distance %h, expected %h", result.distance, want.distance));
        end
      end
    end
  end

endmodule

// ===== tb/tb_ray_sphere_intersection.sv =====
// Testbench top: clock, reset, ray stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps
module tb_ray_sphere_intersection import rsi_pkg::*;;

  localparam int ONE        = 1 << RSI_FRAC_BITS;
  localparam int LATENCY    = 3 * RSI_COORD_WIDTH + 16;
  localparam int CYCLE_CAP  = 300000;
  localparam int RAND_RAYS  = 400;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   quiet;

  rsi_ray_if ray_ch ();
  rsi_hit_if hit_ch ();

  ray_sphere_intersection dut (.clk(clk), .rst(rst), .ray(ray_ch), .result(hit_ch));

  rsi_hit_checker checker_i (
    .clk(clk), .rst(rst), .ray(ray_ch), .result(hit_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** ray_sphere_intersection: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts, none once the run goes quiet.
  int stall_left;
  always @(posedge clk) begin
    if (rst || quiet) begin
      hit_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      hit_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      hit_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      hit_ch.ready <= 1'b1;
    end
  end

  task automatic send_ray(input int ox, oy, oz, dx, dy, dz, cx, cy, cz,
                          input logic [30:0] rad);
    bit took;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      ray_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= ox; ray_ch.origin_y <= oy; ray_ch.origin_z <= oz;
    ray_ch.dir_x <= dx; ray_ch.dir_y <= dy; ray_ch.dir_z <= dz;
    ray_ch.center_x <= cx; ray_ch.center_y <= cy; ray_ch.center_z <= cz;
    ray_ch.sphere_radius <= rad;
    // Hold the item until a transfer; ready is settled by the falling edge.
    do begin
      @(negedge clk);
      took = ray_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic int span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  int ox, oy, oz, cx, cy, cz, dx, dy, dz, sh;
  logic [30:0] rad;

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    cycles = 0;
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    ray_ch.center_x = '0; ray_ch.center_y = '0; ray_ch.center_z = '0;
    ray_ch.sphere_radius = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases.
    send_ray(-5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);              // plain hit at 4
    send_ray(-5*ONE, 3*ONE, 0, ONE, 0, 0, 0, 0, 0, ONE);          // miss
    send_ray(-5*ONE, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE);            // tangent
    send_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0, 2*ONE);                 // origin inside
    send_ray(5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);               // sphere behind
    send_ray(-5*ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE);                // zero direction
    send_ray(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);                // on the surface
    send_ray(-ONE - 1, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);            // root just above zero
    send_ray(-ONE + 1, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE);           // tiny positive root
    send_ray(-30000*ONE, 0, 0, 1, 0, 0, 0, 0, 0, ONE);            // saturated distance
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
    send_ray(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, '1);
    send_ray(32'h7FFF_FFFF, 0, 0, -1, 0, 0, 32'h8000_0000, 0, 0, 0);
    send_ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0);                 // zero radius at origin
    send_ray(-3*ONE, -4*ONE, 0, 3*ONE, 4*ONE, 0, 0, 0, 0, 5*ONE); // |L| and radius cancel

    for (int i = 0; i < RAND_RAYS; i++) begin
      if (i > RAND_RAYS - 60) quiet = 1'b1;
      if ($urandom_range(0, 9) < 3) begin
        // Noise across the full field range.
        send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, 31'($urandom));
      end else begin
        // Aim roughly at the sphere so most rays reach the root logic.
        cx = span(1 << 22); cy = span(1 << 22); cz = span(1 << 22);
        ox = span(1 << 23); oy = span(1 << 23); oz = span(1 << 23);
        rad = 31'($urandom_range(1, 1 << $urandom_range(8, 22)));
        sh = $urandom_range(0, 8);
        dx = ((cx - ox) >>> sh) + span(1 << 14);
        dy = ((cy - oy) >>> sh) + span(1 << 14);
        dz = ((cz - oz) >>> sh) + span(1 << 14);
        if ($urandom_range(0, 7) == 0) begin
          dx = -dx; dy = -dy; dz = -dz;
        end
        send_ray(ox, oy, oz, dx, dy, dz, cx, cy, cz, rad);
      end
    end
    ray_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0)
      $display("** ray_sphere_intersection: PASSED **");
    else
      $display("** ray_sphere_intersection: FAILED **");
    $finish;
  end

endmodule
